// ===== sv/ppmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmfd_pkg
// Shared types and constants of the PPM frame decoder: register indexes,
// reset values, stream widths, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ppmfd_pkg;

    // Field widths fixed by the item layout.
    localparam int TICK_W   = 14;
    localparam int THR_W    = 13;
    localparam int CNT_W    = 5;
    localparam int CHIDX_W  = 4;
    localparam int VALUE_W  = 14;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 2;

    // Limits and reset values.
    localparam int MAX_CHANNELS_DEF = 16;
    localparam logic [TICK_W-1:0] TICK_MAX        = 14'd16383;
    localparam logic [THR_W-1:0]  SYNC_THR_RST    = 13'd6000;
    localparam logic [THR_W-1:0]  NEUTRAL_OFS_RST = 13'd3000;
    localparam logic [CNT_W-1:0]  CHAN_CNT_RST    = 5'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THR    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_OFS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_CNT    = 2'd2;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // an input item is taken this cycle
        logic load_out;  // the next channel result is loaded into the output register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sync_hit;  // the item on the input is an edge that ends a frame
        logic emit_last; // the channel being emitted is the last of the frame
        logic out_free;  // the output register can take a result this cycle
    } t_dp_status;

endpackage : ppmfd_pkg

`default_nettype wire

// ===== sv/ppmfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppmfd_ctrl
// Controller of the PPM frame decoder. Takes input items while idle and,
// after a frame gap, steps the datapath through the channel results.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmfd_ctrl (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  ppmfd_pkg::t_dp_status   i_status,
    output ppmfd_pkg::t_ctrl_cmd    o_cmd
);
    import ppmfd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state: a frame gap starts the emit pass, the last result ends it.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.sync_hit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: input is taken only while idle, results are loaded while emitting.
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_EMIT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule : ppmfd_ctrl

`default_nettype wire

// ===== sv/ppmfd_datapath.sv =====
// ----------------------------------------------------------------------------
// ppmfd_datapath
// Datapath of the PPM frame decoder: configuration registers, tick counter,
// channel position, pulse width store and the registered result output.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmfd_datapath #(
    parameter int MAX_CHANNELS = ppmfd_pkg::MAX_CHANNELS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // Configuration writes
    input  wire                                   i_cfg_valid,
    input  wire  [ppmfd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [ppmfd_pkg::THR_W-1:0]           i_cfg_data,
    // Input item field
    input  wire                                   i_rising_edge,
    // Controller interface
    input  ppmfd_pkg::t_ctrl_cmd                  i_cmd,
    output ppmfd_pkg::t_dp_status                 o_status,
    // Result output
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic [ppmfd_pkg::CHIDX_W-1:0]         o_channel_index,
    output logic [ppmfd_pkg::VALUE_W-1:0]         o_channel_value,
    output logic                                  o_last_in_frame
);
    import ppmfd_pkg::*;

    localparam int IDX_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int STORE_DEPTH = 1 << IDX_W;

    // Configuration registers
    logic [THR_W-1:0]   r_sync_thr;
    logic [THR_W-1:0]   r_neutral_ofs;
    logic [CNT_W-1:0]   r_chan_cnt;

    // Frame state
    logic [TICK_W-1:0]  r_tick;
    logic [CHIDX_W-1:0] r_pos;
    logic [THR_W-1:0]   r_store [STORE_DEPTH];
    logic [CHIDX_W-1:0] r_emit_idx;

    // Output register
    logic                r_out_valid;
    logic [CHIDX_W-1:0]  r_out_index;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_last;

    logic [TICK_W-1:0]  w_tick_inc;
    logic [CNT_W-1:0]   w_active;
    logic [CHIDX_W-1:0] w_last_pos;
    logic [CHIDX_W-1:0] w_pos;
    logic [CNT_W-1:0]   w_pos_inc;
    logic [CHIDX_W-1:0] n_pos;
    logic [VALUE_W-1:0] w_value;
    logic               w_emit_last;

    // Configuration write port; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_thr    <= SYNC_THR_RST;
            r_neutral_ofs <= NEUTRAL_OFS_RST;
            r_chan_cnt    <= CHAN_CNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC_THR:    r_sync_thr    <= i_cfg_data;
                CFG_NEUTRAL_OFS: r_neutral_ofs <= i_cfg_data;
                CFG_CHAN_CNT:    r_chan_cnt    <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Active channel count, clamped to one through MAX_CHANNELS.
    always_comb begin
        if (r_chan_cnt == '0) begin
            w_active = CNT_W'(1);
        end else if (r_chan_cnt > CNT_W'(MAX_CHANNELS)) begin
            w_active = CNT_W'(MAX_CHANNELS);
        end else begin
            w_active = r_chan_cnt;
        end
        w_last_pos = CHIDX_W'(w_active - CNT_W'(1));
    end

    // Saturating tick count including the current tick, and the sync test.
    assign w_tick_inc        = (r_tick == TICK_MAX) ? r_tick : r_tick + TICK_W'(1);
    assign o_status.sync_hit = i_rising_edge && (w_tick_inc > {1'b0, r_sync_thr});

    // Slot for a short interval and the position that follows it.
    always_comb begin
        w_pos     = (r_pos > w_last_pos) ? w_last_pos : r_pos;
        w_pos_inc = {1'b0, w_pos} + CNT_W'(1);
        n_pos     = (w_pos_inc >= w_active) ? w_last_pos : w_pos_inc[CHIDX_W-1:0];
    end

    // Tick counter, channel position and width store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_pos  <= '0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else if (i_cmd.accept) begin
            if (!i_rising_edge) begin
                r_tick <= w_tick_inc;
            end else begin
                r_tick <= '0;
                if (o_status.sync_hit) begin
                    r_pos <= '0;
                end else begin
                    r_store[w_pos[IDX_W-1:0]] <= w_tick_inc[THR_W-1:0];
                    r_pos <= n_pos;
                end
            end
        end
    end

    // Emit counter walks the channels of one frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_idx <= '0;
        end else if (i_cmd.accept) begin
            r_emit_idx <= '0;
        end else if (i_cmd.load_out) begin
            r_emit_idx <= r_emit_idx + CHIDX_W'(1);
        end
    end

    assign w_emit_last = ({1'b0, r_emit_idx} + CNT_W'(1)) == w_active;
    assign w_value     = {1'b0, r_store[r_emit_idx[IDX_W-1:0]]} - {1'b0, r_neutral_ofs};

    // Output register; it frees up when the receiver takes the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_index <= r_emit_idx;
            r_out_value <= w_value;
            r_out_last  <= w_emit_last;
        end
    end

    assign o_status.emit_last = w_emit_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_channel_value = r_out_value;
    assign o_last_in_frame = r_out_last;

endmodule : ppmfd_datapath

`default_nettype wire

// ===== sv/ppm_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// ppm_frame_decoder_unit
// Decodes an RC PPM frame from a stream of prescaled timer ticks.
//
// Usage:
//   Slave stream: one item per timer tick, tdata bit 0 set when the PPM line
//   rose during that tick. Ticks since the last edge are counted, saturating
//   at 16383. An edge after a long interval (above sync_threshold) is a frame
//   gap; an interval not above it is stored as the width of the current channel.
//   Master stream: after each frame gap, one item per active channel, in order
//   from channel 0, holding the channel number and the stored width minus
//   neutral_offset; tlast marks the last channel.
//   Config channel: index 0 sync_threshold, 1 neutral_offset, 2 channel_count.
//   Writes are taken every cycle and should be made while the block is idle.
// Sequence:
//   Ticks without a frame gap are taken while idle. A frame gap tick moves the
//   controller to emit, which loads one channel result at a time into the
//   single output register; the next tick is taken after the last result is
//   loaded. The first result becomes valid once the controller has entered
//   emit and then loaded it into the output register.
// Reset and stall:
//   Reset restores the register defaults, clears counters and all widths.
//   When the master side stalls, emission pauses with the result held.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_frame_decoder_unit #(
    parameter int MAX_CHANNELS = ppmfd_pkg::MAX_CHANNELS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // Configuration write channel
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [ppmfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [ppmfd_pkg::THR_W-1:0]          i_cfg_data,
    // Tick stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [ppmfd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] rising_edge, [7:1] zero
    // Channel result stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [ppmfd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [3:0] channel_index,
                                                                 // [17:4] channel_value,
                                                                 // [23:18] zero
    output logic                                 m_axis_tlast   // last_in_frame
);
    import ppmfd_pkg::*;

    t_ctrl_cmd          w_cmd;
    t_dp_status         w_status;
    logic [CHIDX_W-1:0] w_channel_index;
    logic [VALUE_W-1:0] w_channel_value;

    assign o_cfg_ready = 1'b1;

    ppmfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ppmfd_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_rising_edge   (s_axis_tdata[0]),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_channel_index (w_channel_index),
        .o_channel_value (w_channel_value),
        .o_last_in_frame (m_axis_tlast)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {
        {(OUT_TDATA_W - CHIDX_W - VALUE_W){1'b0}},
        w_channel_value,
        w_channel_index
    };

endmodule : ppm_frame_decoder_unit

`default_nettype wire
